[design/rrag_pkg.sv]
package rrag_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SEQ_W      = 32;
    localparam int CNT_W      = 16;
    localparam int WPK_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACK_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PACKETS = 1'd1;

    localparam logic [CNT_W-1:0] THRESHOLD_RST = 16'd1;
    localparam logic [WPK_W-1:0] WINDOW_RST    = 5'd16;

    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_ACK_REQ = 1'b1;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_NAK = 1'b1;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_INORDER,
        CLS_EMIT
    } class_t;

    typedef struct packed {
        logic start;
        logic step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        class_t cls;
        logic   more;
        logic   out_free;
    } status_t;

endpackage

[design/rrag_in_if.sv]
interface rrag_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [rrag_pkg::SEQ_W-1:0]   seq_num;

    modport source (output valid, output func, output seq_num, input ready);
    modport sink   (input valid, input func, input seq_num, output ready);
endinterface

[design/rrag_out_if.sv]
interface rrag_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [rrag_pkg::SEQ_W-1:0]   ack_seq;
    logic                         last;

    modport source (output valid, output kind, output ack_seq, output last, input ready);
    modport sink   (input valid, input kind, input ack_seq, input last, output ready);
endinterface

[design/rrag_ctrl.sv]
module rrag_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rrag_pkg::status_t status,
    output rrag_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.start = in_valid && in_ready_reg;
                if (in_valid && in_ready_reg)
                begin
                    unique case (status.cls)
                        rrag_pkg::CLS_INORDER: state_next = ST_DRAIN;
                        rrag_pkg::CLS_EMIT:    state_next = ST_FLUSH;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAIN:
            begin
                cmd.step = status.out_free;
                if (status.out_free && !status.more)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

[design/rrag_dp.sv]
module rrag_dp
#(
    parameter int WINDOW = rrag_pkg::WINDOW_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrag_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rrag_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_func,
    input  logic [rrag_pkg::SEQ_W-1:0]      in_seq_num,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_kind,
    output logic [rrag_pkg::SEQ_W-1:0]      out_ack_seq,
    output logic                            out_last,
    input  rrag_pkg::cmd_t                  cmd,
    output rrag_pkg::status_t               status
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [rrag_pkg::CNT_W-1:0] thr_reg;
    logic [rrag_pkg::WPK_W-1:0] wpk_reg;
    logic [rrag_pkg::SEQ_W-1:0] ne_reg,  ne_next;
    logic [rrag_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [WINDOW-1:0]          map_reg, map_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       pend_kind_reg,  pend_kind_next;
    logic [rrag_pkg::SEQ_W-1:0] pend_seq_reg,   pend_seq_next;
    logic                       out_valid_reg,  out_valid_next;
    logic                       out_kind_reg,   out_kind_next;
    logic [rrag_pkg::SEQ_W-1:0] out_seq_reg,    out_seq_next;
    logic                       out_last_reg,   out_last_next;

    logic [rrag_pkg::SEQ_W-1:0] diff;
    logic [rrag_pkg::SEQ_W-1:0] win;
    logic                       ne_nz;
    logic                       mark;
    logic                       emit_kind;
    rrag_pkg::class_t           cls;
    logic [WINDOW-1:0]          map_sh;
    logic [rrag_pkg::SEQ_W-1:0] ne_inc;
    logic [rrag_pkg::CNT_W-1:0] cnt_inc;
    logic                       hit;
    logic                       step_emit;
    logic                       out_load;

    assign diff  = in_seq_num - ne_reg;
    assign win   = ({27'd0, wpk_reg} > rrag_pkg::SEQ_W'(WINDOW)) ? rrag_pkg::SEQ_W'(WINDOW)
                                                                : {27'd0, wpk_reg};
    assign ne_nz = (ne_reg != '0);

    always_comb
    begin
        cls       = rrag_pkg::CLS_NONE;
        mark      = 1'b0;
        emit_kind = rrag_pkg::KIND_ACK;
        if (in_func == rrag_pkg::FUNC_ACK_REQ)
        begin
            cls = ne_nz ? rrag_pkg::CLS_EMIT : rrag_pkg::CLS_NONE;
        end
        else if (in_seq_num == ne_reg)
        begin
            cls = rrag_pkg::CLS_INORDER;
        end
        else if (in_seq_num > ne_reg)
        begin
            if (diff >= win)
            begin
                cls       = ne_nz ? rrag_pkg::CLS_EMIT : rrag_pkg::CLS_NONE;
                emit_kind = rrag_pkg::KIND_NAK;
            end
            else
            begin
                mark = 1'b1;
            end
        end
    end

    assign map_sh    = map_reg >> 1;
    assign ne_inc    = ne_reg + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign hit       = (cnt_inc >= thr_reg);
    assign step_emit = hit && (ne_inc != '0);

    always_comb
    begin
        ne_next         = ne_reg;
        cnt_next        = cnt_reg;
        map_next        = map_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_seq_next   = pend_seq_reg;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;

        if (cmd.start)
        begin
            if (mark)
            begin
                map_next = map_reg | (WINDOW'(1) << diff[IDX_W-1:0]);
            end
            if (cls == rrag_pkg::CLS_EMIT)
            begin
                pend_valid_next = 1'b1;
                pend_kind_next  = emit_kind;
                pend_seq_next   = ne_reg - 1'b1;
            end
        end

        if (cmd.step)
        begin
            map_next = map_sh;
            ne_next  = ne_inc;
            cnt_next = hit ? '0 : cnt_inc;
            if (step_emit)
            begin
                if (pend_valid_reg)
                begin
                    out_load      = 1'b1;
                    out_kind_next = pend_kind_reg;
                    out_seq_next  = pend_seq_reg;
                    out_last_next = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_kind_next  = rrag_pkg::KIND_ACK;
                pend_seq_next   = ne_reg;
            end
        end

        if (cmd.flush && pend_valid_reg)
        begin
            out_load        = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_seq_next    = pend_seq_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= rrag_pkg::THRESHOLD_RST;
            wpk_reg        <= rrag_pkg::WINDOW_RST;
            ne_reg         <= '0;
            cnt_reg        <= '0;
            map_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    rrag_pkg::REG_ACK_THRESHOLD:  thr_reg <= cfg_wdata;
                    rrag_pkg::REG_WINDOW_PACKETS: wpk_reg <= cfg_wdata[rrag_pkg::WPK_W-1:0];
                    default:                      thr_reg <= thr_reg;
                endcase
            end
            ne_reg         <= ne_next;
            cnt_reg        <= cnt_next;
            map_reg        <= map_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_seq_reg  <= pend_seq_next;
        out_kind_reg  <= out_kind_next;
        out_seq_reg   <= out_seq_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_ack_seq = out_seq_reg;
    assign out_last    = out_last_reg;

    assign status.cls      = cls;
    assign status.more     = map_sh[0];
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

[design/reorder_receiver_ack_gen_core.sv]
// channel   dir  beat fields                 handshake
// in_ch     in   func, seq_num               valid/ready
// out_ch    out  kind, ack_seq, last         valid/ready
// cfg       in   cfg_idx, cfg_wdata          cfg_we, no stall
//
// Ack request, NAK, stale or buffered packet: accepted, then a flush if there is a result.
// Expected packet: accepted, then drain steps through it and the buffered run behind it, then a flush.
// A result waits in a holding register until the next one or the flush, which sets last.
// A stalled out_ch freezes drain and flush; in_ch is not ready until the item is finished.
// rst_n clears sequence, count, bitmap and valids; registers return to threshold 1, window 16.
module reorder_receiver_ack_gen_core
#(
    parameter int WINDOW = rrag_pkg::WINDOW_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrag_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rrag_pkg::CFG_DATA_W-1:0] cfg_wdata,
    rrag_in_if.sink                         in_ch,
    rrag_out_if.source                      out_ch
);

    rrag_pkg::cmd_t    cmd;
    rrag_pkg::status_t status;

    rrag_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rrag_dp
    #(
        .WINDOW (WINDOW)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .in_func     (in_ch.func),
        .in_seq_num  (in_ch.seq_num),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_kind    (out_ch.kind),
        .out_ack_seq (out_ch.ack_seq),
        .out_last    (out_ch.last),
        .cmd         (cmd),
        .status      (status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.flush) |-> status.out_free)
        else $error("drain or flush issued while output register is blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !(cmd.step || cmd.flush))
        else $error("new beat started during drain or flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && status.cls == rrag_pkg::CLS_INORDER) |=> !in_ch.ready)
        else $error("input ready during drain");

endmodule

[dv/reorder_receiver_ack_gen_core_tb.sv]
`timescale 1ns / 1ps

module reorder_receiver_ack_gen_core_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 28;
    localparam int THR_SET[8] = '{1, 2, 0, 4, 1, 65535, 3, 1};
    localparam int WIN_SET[8] = '{16, 8, 4, 2, 1, 16, 0, 31};

    typedef struct {
        logic                        func;
        logic [rrag_pkg::SEQ_W-1:0]  seq;
    } pkt_t;

    typedef struct {
        logic                        kind;
        logic [rrag_pkg::SEQ_W-1:0]  ack_seq;
        logic                        last;
    } ack_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [rrag_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [rrag_pkg::CFG_DATA_W-1:0] cfg_wdata;

    rrag_in_if  pkt_ch ();
    rrag_out_if ack_ch ();

    reorder_receiver_ack_gen_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_ch     (pkt_ch),
        .out_ch    (ack_ch)
    );

    // receiver state as predicted
    logic [rrag_pkg::SEQ_W-1:0]      rx_next = '0;
    logic [rrag_pkg::CNT_W-1:0]      rx_count = '0;
    logic [rrag_pkg::WINDOW_DEF-1:0] rx_map = '0;
    logic [rrag_pkg::CNT_W-1:0]      thr_q = rrag_pkg::THRESHOLD_RST;
    logic [rrag_pkg::WPK_W-1:0]      win_q = rrag_pkg::WINDOW_RST;

    pkt_t      pkt_q[$];
    ack_beat_t ack_q[$];

    int   err_count = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;
    logic calm = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_err(input string msg);
        if (err_count < 40)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic int eff_window();
        return (win_q > rrag_pkg::WINDOW_DEF) ? rrag_pkg::WINDOW_DEF : int'(win_q);
    endfunction

    task automatic emit_ack(input logic kind, inout int emitted);
        ack_beat_t b;
        if (rx_next != '0)
        begin
            b.kind = kind;
            b.ack_seq = rx_next - 1;
            b.last = 1'b0;
            ack_q.push_back(b);
            emitted++;
        end
    endtask

    task automatic take_in_order(inout int emitted);
        rx_next = rx_next + 1;
        rx_count = rx_count + 1'b1;
        if (rx_count >= thr_q)
        begin
            rx_count = '0;
            emit_ack(rrag_pkg::KIND_ACK, emitted);
        end
    endtask

    task automatic predict_beat(input logic func, input logic [rrag_pkg::SEQ_W-1:0] seq);
        int emitted;
        int w;
        logic [rrag_pkg::SEQ_W-1:0] d;
        emitted = 0;
        w = eff_window();
        if (func == rrag_pkg::FUNC_ACK_REQ)
        begin
            emit_ack(rrag_pkg::KIND_ACK, emitted);
        end
        else if (seq < rx_next)
        begin
            // stale, dropped
        end
        else if (seq == rx_next)
        begin
            rx_map = rx_map >> 1;
            take_in_order(emitted);
            while (rx_map[0])
            begin
                rx_map = rx_map >> 1;
                take_in_order(emitted);
            end
        end
        else
        begin
            d = seq - rx_next;
            if (d >= w)
                emit_ack(rrag_pkg::KIND_NAK, emitted);
            else
                rx_map[d] = 1'b1;
        end
        if (emitted > 0)
            ack_q[ack_q.size()-1].last = 1'b1;
    endtask

    task automatic check_result(input logic kind, input logic [rrag_pkg::SEQ_W-1:0] seq,
                                input logic last);
        ack_beat_t want;
        if (ack_q.size() == 0)
        begin
            report_err($sformatf("unexpected beat kind=%0d ack_seq=%0d last=%0d",
                                 kind, seq, last));
            return;
        end
        want = ack_q[0];
        ack_q.delete(0);
        if (kind !== want.kind)
            report_err($sformatf("kind %0d, want %0d", kind, want.kind));
        if (seq !== want.ack_seq)
            report_err($sformatf("ack_seq %0d, want %0d", seq, want.ack_seq));
        if (last !== want.last)
            report_err($sformatf("last %0d, want %0d", last, want.last));
    endtask

    task automatic add_pkt(input logic func, input logic [rrag_pkg::SEQ_W-1:0] seq);
        pkt_t p;
        p.func = func;
        p.seq = seq;
        pkt_q.push_back(p);
    endtask

    task automatic set_config(input logic [rrag_pkg::CFG_DATA_W-1:0] thr,
                              input logic [rrag_pkg::CFG_DATA_W-1:0] win);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= rrag_pkg::REG_ACK_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_idx <= rrag_pkg::REG_WINDOW_PACKETS;
        cfg_wdata <= win;
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_q = thr;
        win_q = win[rrag_pkg::WPK_W-1:0];
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pkt_q.size() != 0 || pkt_ch.valid || ack_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly in-window runs, shuffled, plus ack requests, stale and far packets
    task automatic gen_traffic(input int n);
        int w;
        int k;
        int made;
        int r;
        int j;
        int t;
        int order[16];
        logic [rrag_pkg::SEQ_W-1:0] base;
        logic [rrag_pkg::SEQ_W-1:0] s;
        base = rx_next;
        w = eff_window();
        made = 0;
        while (made < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                add_pkt(rrag_pkg::FUNC_ACK_REQ, $urandom);
                made++;
            end
            else if (r < 15)
            begin
                if (base != '0)
                begin
                    add_pkt(rrag_pkg::FUNC_DATA,
                            base - $urandom_range(1, (base > 40) ? 40 : base));
                    made++;
                end
            end
            else if (r < 22)
            begin
                if ($urandom_range(0, 1) == 1)
                    s = $urandom;
                else
                    s = base + w + $urandom_range(0, 40);
                add_pkt(rrag_pkg::FUNC_DATA, s);
                made++;
            end
            else
            begin
                k = $urandom_range(1, (w > 1) ? w : 1);
                for (j = 0; j < k; j++)
                    order[j] = j;
                for (j = k - 1; j > 0; j--)
                begin
                    r = $urandom_range(0, j);
                    t = order[j];
                    order[j] = order[r];
                    order[r] = t;
                end
                for (j = 0; j < k; j++)
                begin
                    add_pkt(rrag_pkg::FUNC_DATA, base + order[j]);
                    made++;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        add_pkt(rrag_pkg::FUNC_DATA, base + order[j]);
                        made++;
                    end
                end
                base = base + k;
            end
        end
    endtask

    // packet driver
    always @(posedge clk)
    begin
        pkt_t p;
        if (rst_n)
        begin
            if (pkt_ch.valid && pkt_ch.ready)
                predict_beat(pkt_ch.func, pkt_ch.seq_num);
            if (!pkt_ch.valid || pkt_ch.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    pkt_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    tx_gap <= $urandom_range(0, 6);
                    pkt_ch.valid <= 1'b0;
                end
                else if (pkt_q.size() != 0)
                begin
                    p = pkt_q[0];
                    pkt_q.delete(0);
                    pkt_ch.valid <= 1'b1;
                    pkt_ch.func <= p.func;
                    pkt_ch.seq_num <= p.seq;
                end
                else
                begin
                    pkt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ack monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ack_ch.valid && ack_ch.ready)
                check_result(ack_ch.kind, ack_ch.ack_seq, ack_ch.last);
            if (hold_go && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES;
                ack_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                ack_ch.ready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                ack_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rx_gap <= $urandom_range(0, 6);
                ack_ch.ready <= 1'b0;
            end
            else
            begin
                ack_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pkt_ch.valid && pkt_ch.ready) || (ack_ch.valid && ack_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", quiet_cycles);
                $display("reorder_receiver_ack_gen_core_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int j;
        int p;
        logic [rrag_pkg::SEQ_W-1:0] b;
        logic [rrag_pkg::CFG_DATA_W-1:0] thr;
        logic [rrag_pkg::CFG_DATA_W-1:0] win;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = rrag_pkg::REG_ACK_THRESHOLD;
        cfg_wdata = '0;
        pkt_ch.valid = 1'b0;
        pkt_ch.func = rrag_pkg::FUNC_DATA;
        pkt_ch.seq_num = '0;
        ack_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings; nothing to acknowledge until packet 0 lands
        add_pkt(rrag_pkg::FUNC_ACK_REQ, 32'd0);
        add_pkt(rrag_pkg::FUNC_DATA, 32'hFFFF_FFFF);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd3);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd0);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd0);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd1);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd2);
        for (j = 5; j < 20; j++)
            add_pkt(rrag_pkg::FUNC_DATA, j);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd20);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd4);
        add_pkt(rrag_pkg::FUNC_ACK_REQ, 32'hFFFF_FFFF);
        add_pkt(rrag_pkg::FUNC_DATA, 32'h8000_0000);
        settle();

        // zero threshold, zero window
        set_config(16'd0, 16'd0);
        b = rx_next;
        add_pkt(rrag_pkg::FUNC_DATA, b);
        add_pkt(rrag_pkg::FUNC_DATA, b);
        add_pkt(rrag_pkg::FUNC_DATA, b + 2);
        add_pkt(rrag_pkg::FUNC_DATA, b + 1);
        add_pkt(rrag_pkg::FUNC_ACK_REQ, 32'h5555_5555);
        add_pkt(rrag_pkg::FUNC_DATA, 32'd0);
        settle();

        // top threshold, window register above the buffer size
        set_config(16'hFFFF, 16'd31);
        b = rx_next;
        for (j = 0; j < 5; j++)
            add_pkt(rrag_pkg::FUNC_DATA, b + j);
        add_pkt(rrag_pkg::FUNC_DATA, b + 20);
        add_pkt(rrag_pkg::FUNC_DATA, b + 21);
        add_pkt(rrag_pkg::FUNC_DATA, b + 20);
        add_pkt(rrag_pkg::FUNC_ACK_REQ, 32'hAAAA_AAAA);
        settle();

        // threshold dropped under the count; window 1 with junk upper bits
        set_config(16'd3, 16'hFFE1);
        b = rx_next;
        add_pkt(rrag_pkg::FUNC_DATA, b);
        add_pkt(rrag_pkg::FUNC_DATA, b + 2);
        add_pkt(rrag_pkg::FUNC_DATA, b + 1);
        add_pkt(rrag_pkg::FUNC_ACK_REQ, 32'd0);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p < 8)
            begin
                thr = THR_SET[p];
                win = WIN_SET[p];
            end
            else
            begin
                thr = $urandom_range(0, 8);
                win = $urandom_range(0, 31);
            end
            set_config(thr, win);
            if (p == PHASES - 1)
                calm = 1'b1;
            gen_traffic(PHASE_ITEMS);
            if (p == 0)
                hold_go = 1'b1;
            settle();
        end

        if (err_count == 0)
            $display("reorder_receiver_ack_gen_core_tb OK");
        else
            $display("reorder_receiver_ack_gen_core_tb NOT OK");
        $finish;
    end

endmodule
